// ----- rtl/fbpa_pkg.sv -----
package fbpa_pkg;

  // Pool geometry
  localparam int REGION_SLOTS = 256;
  localparam int MAX_REGIONS  = 16;

  // Field and state widths
  localparam int IDX_W       = 12;
  localparam int STORE_DEPTH = 1 << IDX_W;
  localparam int LINK_W      = IDX_W + 1;                  // {valid, next index}
  localparam int CFG_W       = 9;
  localparam int SLOT_W      = $clog2(REGION_SLOTS + 1);
  localparam int REGION_W    = $clog2(MAX_REGIONS + 1);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [CFG_W-1:0] REGION_BLOCKS_RESET = CFG_W'(256);

  typedef enum logic {
    REG_REGION_BLOCKS = 1'b0
  } reg_idx_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic {
    ST_OK        = 1'b0,
    ST_EXHAUSTED = 1'b1
  } status_t;

  typedef enum logic {
    FB_IDLE = 1'b0,
    FB_POP  = 1'b1
  } fb_state_t;

endpackage

// ----- rtl/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator. Each request either allocates a block
// (in_action 0) or frees the block named by in_block_index (in_action 1), and
// produces exactly one result. Allocation pops the LIFO free list when it is
// not empty; otherwise it hands out the next untouched slot of the current
// region (index = region * 256 + slot), opening a new region when the current
// one holds region_blocks slots. With the list empty and all 16 regions full,
// the result is index 0 with status 1 and nothing changes. Frees are pushed
// unchecked and echo the index. Links live in a 4096 x 13 synchronous RAM,
// one entry per block, valid bit included. A free or bump allocation goes
// straight to the output register; a pop first passes through FB_POP, as the
// next-head link comes back from the RAM in the cycle after the read. Results
// wait in an output register, so a new request is taken while the previous
// result is being taken. The user must write region_blocks (address 0) only
// while idle (not enforced here); 0 acts as 1 and values above 256 act as 256.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [IDX_W-1:0]     in_block_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_granted_index,
  output logic                 out_status,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  fb_state_t            state_r, state_nxt;
  logic [CFG_W-1:0]     region_blocks_r;
  logic [IDX_W-1:0]     free_head_r, free_head_nxt;
  logic                 free_nonempty_r, free_nonempty_nxt;
  logic [SLOT_W-1:0]    bump_slot_r, bump_slot_nxt;
  logic [REGION_W-1:0]  regions_open_r, regions_open_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_index_r, out_index_nxt;
  logic                 out_status_r, out_status_nxt;

  logic                 in_take;
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LINK_W-1:0]    ram_wdata, ram_rdata;
  logic [SLOT_W-1:0]    eff_blocks;
  logic                 cfg_write;

  // Configuration register: written on the access phase, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_REGION_BLOCKS) ? PDATA_W'(region_blocks_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_blocks_r <= REGION_BLOCKS_RESET;
    end else if (cfg_write && paddr[2] == REG_REGION_BLOCKS) begin
      region_blocks_r <= pwdata[CFG_W-1:0];
    end
  end

  // Clamp the region size to 1..REGION_SLOTS.
  always_comb begin
    if (region_blocks_r == '0) begin
      eff_blocks = SLOT_W'(1);
    end else if (32'(region_blocks_r) > REGION_SLOTS) begin
      eff_blocks = SLOT_W'(REGION_SLOTS);
    end else begin
      eff_blocks = SLOT_W'(region_blocks_r);
    end
  end

  // Take a request only when idle and the output register is free or
  // being emptied this cycle.
  assign in_ready = (state_r == FB_IDLE) && (!out_valid_r || out_ready);
  assign in_take  = in_valid && in_ready;

  // Push writes {was list nonempty, old head} at the freed block; a pop
  // reads the head's link.
  assign ram_we    = in_take && (in_action == ACT_FREE);
  assign ram_waddr = in_block_index;
  assign ram_wdata = {free_nonempty_r, free_head_r};
  assign ram_re    = in_take && (in_action == ACT_ALLOC) && free_nonempty_r;

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (STORE_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (free_head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    free_head_nxt     = free_head_r;
    free_nonempty_nxt = free_nonempty_r;
    bump_slot_nxt     = bump_slot_r;
    regions_open_nxt  = regions_open_r;
    out_valid_nxt     = out_valid_r;
    out_index_nxt     = out_index_r;
    out_status_nxt    = out_status_r;

    // Drop the result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      FB_IDLE: begin
        if (in_take) begin
          if (in_action == ACT_FREE) begin
            free_head_nxt     = in_block_index;
            free_nonempty_nxt = 1'b1;
            out_valid_nxt     = 1'b1;
            out_index_nxt     = in_block_index;
            out_status_nxt    = ST_OK;
          end else if (free_nonempty_r) begin
            // Wait for the head's link to come back from the RAM.
            state_nxt = FB_POP;
          end else if (bump_slot_r < eff_blocks) begin
            out_valid_nxt  = 1'b1;
            out_index_nxt  = IDX_W'(32'(regions_open_r - 1'b1) * REGION_SLOTS
                                    + 32'(bump_slot_r));
            out_status_nxt = ST_OK;
            bump_slot_nxt  = bump_slot_r + 1'b1;
          end else if (32'(regions_open_r) < MAX_REGIONS) begin
            // Open the next region and hand out its first slot.
            regions_open_nxt = regions_open_r + 1'b1;
            bump_slot_nxt    = SLOT_W'(1);
            out_valid_nxt    = 1'b1;
            out_index_nxt    = IDX_W'(32'(regions_open_r) * REGION_SLOTS);
            out_status_nxt   = ST_OK;
          end else begin
            out_valid_nxt  = 1'b1;
            out_index_nxt  = '0;
            out_status_nxt = ST_EXHAUSTED;
          end
        end
      end
      FB_POP: begin
        // Hand out the old head and advance to its link.
        out_valid_nxt     = 1'b1;
        out_index_nxt     = free_head_r;
        out_status_nxt    = ST_OK;
        free_head_nxt     = ram_rdata[IDX_W-1:0];
        free_nonempty_nxt = ram_rdata[IDX_W];
        state_nxt         = FB_IDLE;
      end
      default: begin
        state_nxt = FB_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= FB_IDLE;
      free_head_r     <= '0;
      free_nonempty_r <= 1'b0;
      bump_slot_r     <= '0;
      regions_open_r  <= REGION_W'(1);
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      free_head_r     <= free_head_nxt;
      free_nonempty_r <= free_nonempty_nxt;
      bump_slot_r     <= bump_slot_nxt;
      regions_open_r  <= regions_open_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_index_r;
  assign out_status        = out_status_r;

`ifndef SYNTHESIS
  a_pop_output_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FB_POP) |-> !out_valid_r)
    else $error("output register busy while a pop completes");

  a_pop_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (state_r == FB_POP) && out_valid_r == 1'b0)
    else $error("pop read not followed by the pop cycle");

  a_exhaust_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EXHAUSTED) |->
      (!free_nonempty_r && 32'(regions_open_r) == MAX_REGIONS))
    else $error("exhaustion reported with blocks still available");

  a_regions_range: assert property (@(posedge clk) disable iff (!rst_n)
    (regions_open_r != '0) && (32'(regions_open_r) <= MAX_REGIONS))
    else $error("open region count out of range");
`endif

endmodule

// ----- rtl/fbpa_ram.sv -----
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
